// ===== sv/evu_pkg.sv =====
// Shared constants for the encoder velocity estimator.
// No dependencies; imported by the top level.
`default_nettype none

package evu_pkg;

  // Default widths of the input fields.
  localparam int AngleBitsDef = 14;
  localparam int TimeBitsDef  = 32;

  // Fixed widths of the result fields.
  localparam int SpeedW   = 24;
  localparam int ElapsedW = 32;

  // Signed 24-bit saturation limits.
  localparam logic signed [SpeedW-1:0] SpeedMax = 24'sh7FFFFF;
  localparam logic signed [SpeedW-1:0] SpeedMin = 24'sh800000;

  // Width of the rpm product: speed times 15360 needs 14 more bits; the 16 added bits leave two guard bits.
  localparam int RpmProdW = SpeedW + 16;

endpackage

`default_nettype wire

// ===== sv/evu_bitdiv.sv =====
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Standalone; instantiated by the encoder velocity estimator top level.
`default_nettype none

module evu_bitdiv #(
  parameter int NumW = 23,
  parameter int DenW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic      [NumW-1:0] quot_o
);

  localparam int CntW = $clog2(NumW + 1);

  // The numerator shifts out at the top while quotient bits shift in at the bottom.
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [DenW:0] shifted;
  logic [DenW:0] trial;

  always_comb begin
    shifted = {rem_q, num_q[NumW-1]};
    trial   = shifted - {1'b0, den_q};
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DenW]) begin
        rem_d = trial[DenW-1:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DenW-1:0];
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

// ===== sv/encoder_velocity_estimator_unit.sv =====
// Top level of the encoder velocity estimator: stream ports, sequencer, scaling.
// Depends on evu_pkg and evu_bitdiv.
`default_nettype none

// Each input beat carries one shaft angle sample and the millisecond timer value taken
// with it; each accepted beat yields exactly one output beat. The output carries the time
// elapsed since the previous sample, and, when that time is not zero, a freshly computed
// speed in counts per second (the shortest angle difference times 1000 divided by the
// elapsed time, truncated toward zero) and in rpm times 256 (floored). When the elapsed
// time is zero the last speeds are repeated and tuser is low. One item is processed at a
// time. A sample with a nonzero elapsed time passes the load, divide, saturate, rpm and
// output states before the next ready, one with zero elapsed time only load and output.
// In the divide state the bit-serial divider yields one quotient bit per cycle over
// ANGLE_BITS + 9 quotient bits. The finished beat sits in an output register, so the next
// sample can be accepted while the previous result still waits downstream. Both speeds
// saturate to the signed 24-bit range, which only matters for ANGLE_BITS above 14. The
// first sample after reset is measured against angle zero and time zero.
module encoder_velocity_estimator_unit
  import evu_pkg::*;
#(
  parameter int AngleBits = AngleBitsDef,
  parameter int TimeBits  = TimeBitsDef,
  localparam int InTdataW = ((AngleBits + TimeBits + 7) / 8) * 8,
  localparam int OutTdataW = 2 * SpeedW + ElapsedW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Fields from bit 0 up: angle_counts (AngleBits), timestamp_ms (TimeBits), zero pad.
  input  wire logic [InTdataW-1:0]  s_axis_tdata,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0 up: speed_counts_per_s (24), speed_rpm_q8 (24), elapsed_ms (32).
  output logic [OutTdataW-1:0]      m_axis_tdata,
  // Fields from bit 0 up: updated (1).
  output logic [0:0]                m_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready
);

  // Numerator width: |diff| is at most a half turn, and times 1000 stays below 2^(A+9).
  localparam int NumW = AngleBits + 9;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SAT  = 3'd3;
  localparam logic [2:0] S_RPM  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [AngleBits-1:0] HalfTurn = {1'b1, {(AngleBits-1){1'b0}}};

  logic [2:0] state_q, state_d;

  // Input fields.
  logic [AngleBits-1:0] in_angle;
  logic [TimeBits-1:0]  in_time;

  // Persistent state.
  logic [AngleBits-1:0]     prev_angle_q;
  logic [TimeBits-1:0]      prev_time_q;
  logic signed [SpeedW-1:0] held_speed_q;
  logic signed [SpeedW-1:0] held_rpm_q;

  // Per-item working registers.
  logic [AngleBits-1:0]     angle_q;
  logic [TimeBits-1:0]      elapsed_q;
  logic [AngleBits-1:0]     mag_q;
  logic                     neg_q;
  logic signed [SpeedW-1:0] speed_q;
  logic                     upd_q;

  // Output register.
  logic                     m_valid_q;
  logic [OutTdataW-1:0]     m_data_q;
  logic                     m_upd_q;

  // Front end: wrapped angle difference as sign and magnitude.
  logic [AngleBits:0]   raw_diff;
  logic [AngleBits-1:0] mod_diff;
  logic [AngleBits-1:0] diff_mag;
  logic                 diff_neg;

  // Divider interface.
  logic            div_start;
  logic [NumW-1:0] div_num;
  logic            div_done;
  logic [NumW-1:0] div_quot;

  // Post-processing.
  logic [31:0]                quot_ext;
  logic signed [SpeedW-1:0]   speed_sat;
  logic signed [RpmProdW-1:0] speed_ext;
  logic signed [RpmProdW-1:0] rpm_prod;
  logic signed [RpmProdW-1:0] rpm_shift;
  logic signed [SpeedW-1:0]   rpm_sat;

  logic in_fire;
  logic out_load;

  assign in_angle = s_axis_tdata[AngleBits-1:0];
  assign in_time  = s_axis_tdata[AngleBits+TimeBits-1:AngleBits];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  // The modular difference already is the wrapped difference, except at exactly a half
  // turn, where the sign follows the raw difference.
  always_comb begin
    raw_diff = {1'b0, in_angle} - {1'b0, prev_angle_q};
    mod_diff = raw_diff[AngleBits-1:0];
    diff_mag = mod_diff[AngleBits-1] ? (AngleBits'(0) - mod_diff) : mod_diff;
    diff_neg = mod_diff[AngleBits-1] && !((mod_diff == HalfTurn) && !raw_diff[AngleBits]);
  end

  // Times 1000 as 1024 - 16 - 8; intermediate overflow cancels out modulo 2^NumW.
  assign div_num = (NumW'(mag_q) << 10) - (NumW'(mag_q) << 4) - (NumW'(mag_q) << 3);
  assign div_start = (state_q == S_LOAD) && (elapsed_q != '0);

  evu_bitdiv #(
    .NumW (NumW),
    .DenW (TimeBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (elapsed_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Apply the sign to the truncated quotient and saturate.
  always_comb begin
    quot_ext = 32'(div_quot);
    if (!neg_q) begin
      speed_sat = (quot_ext > 32'(SpeedMax)) ? SpeedMax : SpeedW'(quot_ext);
    end else begin
      speed_sat = (quot_ext > 32'h0080_0000) ? SpeedMin
                                             : (SpeedW'(0) - SpeedW'(quot_ext));
    end
  end

  // rpm * 256 = floor(speed * 15360 / 2^AngleBits); 15360 = 16384 - 1024.
  always_comb begin
    speed_ext = RpmProdW'(speed_q);
    rpm_prod  = (speed_ext <<< 14) - (speed_ext <<< 10);
    rpm_shift = rpm_prod >>> AngleBits;
    if (rpm_shift > RpmProdW'(SpeedMax)) begin
      rpm_sat = SpeedMax;
    end else if (rpm_shift < RpmProdW'(SpeedMin)) begin
      rpm_sat = SpeedMin;
    end else begin
      rpm_sat = rpm_shift[SpeedW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = (elapsed_q == '0) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        state_d = S_RPM;
      end
      S_RPM: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_angle_q <= '0;
      prev_time_q  <= '0;
      held_speed_q <= '0;
      held_rpm_q   <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        prev_time_q <= in_time;
      end
      if (state_q == S_RPM) begin
        held_speed_q <= speed_q;
        held_rpm_q   <= rpm_sat;
        prev_angle_q <= angle_q;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      angle_q   <= in_angle;
      elapsed_q <= in_time - prev_time_q;
      mag_q     <= diff_mag;
      neg_q     <= diff_neg;
    end
    if (state_q == S_LOAD) begin
      upd_q <= (elapsed_q != '0);
    end
    if (state_q == S_SAT) begin
      speed_q <= speed_sat;
    end
    if (out_load) begin
      m_data_q <= {ElapsedW'(elapsed_q), held_rpm_q, held_speed_q};
      m_upd_q  <= upd_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_upd_q;

endmodule

`default_nettype wire
